>>> rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_APPEND_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

endpackage

>>> rtl/sha_round.sv
`timescale 1ns / 1ps
// One compression round per cycle; sixteen-word rolling schedule in registers.
module sha_round
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] msg_word,
    input  word_t       hash_in [8],
    output logic [3:0]  word_sel,
    output logic        busy,
    output logic        done,
    output word_t       vars_out [8]
);

    word_t       v_reg [8];
    word_t       v_next [8];
    word_t       w_reg [16];
    logic [6:0]  rnd_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  r;
    word_t       w, t1, t2, w2, w7, w15, w16, s0, s1;

    assign r = rnd_reg[5:0];
    assign word_sel = r[3:0];
    assign busy = busy_reg;
    assign done = done_reg;
    assign vars_out = v_reg;

    always_comb
    begin
        w2  = w_reg[4'(r - 6'd2)];
        w7  = w_reg[4'(r - 6'd7)];
        w15 = w_reg[4'(r - 6'd15)];
        w16 = w_reg[r[3:0]];
        s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w = (r < 6'd16) ? msg_word : (s1 + w7 + s0 + w16);
        t1 = v_reg[7]
           + ({v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
              ^ {v_reg[4][24:0], v_reg[4][31:25]})
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[r] + w;
        t2 = ({v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
              ^ {v_reg[0][21:0], v_reg[0][31:22]})
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + t2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 7'd1;
                if (rnd_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            v_reg <= hash_in;
        else if (busy_reg)
        begin
            v_reg <= v_next;
            w_reg[r[3:0]] <= w;
        end
    end

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// An append that does not fill a block leaves the hasher idle; one that fills it
// runs 64 rounds in the shared round unit plus load and update, with in_stall high.
// A finish pads byte by byte with one or two compressions, then offers eight
// digest words, one a cycle while out_stall is low.
// Reset: asynchronous, active low; hash set to initial values, counts cleared.
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg;
    logic        fin_reg;
    logic        pend_reg;
    word_t       hash_reg [8];
    word_t       buf_reg [16];
    logic [5:0]  pos_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic [2:0]  cnt_reg;
    logic        accept;
    logic        put;
    logic [7:0]  put_byte;
    logic [5:0]  pos_inc;
    logic        start;
    core_ctl_t   ctl;
    logic [3:0]  wsel;
    word_t       vars [8];
    logic [31:0] msg_word;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign pos_inc = pos_reg + 6'd1;
    assign msg_word = buf_reg[wsel];

    always_comb
    begin
        put = 1'b0;
        put_byte = data_byte;
        unique case (state_reg)
            ST_IDLE: put = accept && (cmd == CMD_APPEND || cmd == CMD_APPEND_FINISH);
            ST_PAD:
            begin
                put = 1'b1;
                put_byte = fin_reg ? 8'h00 : PAD_BYTE;
            end
            ST_LEN:
            begin
                put = 1'b1;
                put_byte = len_reg[63:56];
            end
            default: put = 1'b0;
        endcase
    end

    assign start = put && (pos_inc == 6'd0);
    assign ctl.start = start;

    sha_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .msg_word (msg_word),
        .hash_in  (hash_reg),
        .word_sel (wsel),
        .busy     (ctl.busy),
        .done     (ctl.done),
        .vars_out (vars)
    );

    // big-endian byte lane inside the word
    always_ff @(posedge clk)
    begin
        if (put)
            buf_reg[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= put_byte;
    end

    // fin_reg marks that the 0x80 byte is already in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            pos_reg   <= '0;
            bits_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            if (put)
                pos_reg <= pos_inc;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && cmd != CMD_UNUSED)
                    begin
                        if (cmd == CMD_FINISH)
                            len_reg <= bits_reg;
                        else
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            len_reg  <= bits_reg + 64'd8;
                        end
                        fin_reg  <= 1'b0;
                        pend_reg <= (cmd != CMD_APPEND);
                        cnt_reg  <= '0;
                        if (start)
                            state_reg <= ST_COMP;
                        else if (cmd != CMD_APPEND)
                            state_reg <= ST_PAD;
                    end
                end
                ST_PAD:
                begin
                    fin_reg <= 1'b1;
                    if (start)
                        state_reg <= ST_COMP;
                    else if (pos_inc == LEN_POS)
                        state_reg <= ST_LEN;
                end
                ST_LEN:
                begin
                    len_reg <= {len_reg[55:0], 8'h00};
                    if (start)
                    begin
                        state_reg <= ST_COMP;
                        fin_reg   <= 1'b0;
                        cnt_reg   <= 3'd7;
                    end
                end
                ST_COMP:
                begin
                    if (ctl.done)
                    begin
                        for (int i = 0; i < 8; i++)
                            hash_reg[i] <= hash_reg[i] + vars[i];
                        // cnt 7 marks the length block; otherwise resume where left
                        if (cnt_reg == 3'd7)
                        begin
                            state_reg <= ST_OUT;
                            cnt_reg   <= '0;
                        end
                        else if (pend_reg)
                            state_reg <= (pos_reg == LEN_POS) ? ST_LEN : ST_PAD;
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                        if (cnt_reg == 3'd7)
                        begin
                            state_reg <= ST_IDLE;
                            bits_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= INIT_HASH[i];
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = hash_reg[cnt_reg];
    assign word_index  = cnt_reg;
    assign last_word   = (cnt_reg == 3'd7);

    a_no_out_while_comp: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.busy |-> !out_valid)
        else $error("digest offered during compression");
    a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> ctl.busy && state_reg == ST_COMP)
        else $error("round unit not running after start");
    a_out_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_reg == 6'd0)
        else $error("buffer not empty at digest");

endmodule
